### rtl/core/brfc_pkg.sv
// shared types, widths and codes of the cubic bisection root finder
// no dependencies; imported by the controller, the datapath and the top level

package brfc_pkg;

  // fixed point format of the interval ends, Q8.16
  localparam int FRAC_BITS = 16;
  localparam int INT_BITS  = 8;
  localparam int X_W       = INT_BITS + FRAC_BITS;

  // magnitude widths along the cubic evaluation
  localparam int XM_W = X_W;                       // |x|
  localparam int X2_W = 2 * X_W - 1 - FRAC_BITS;   // |x*x| after the shift
  localparam int P_W  = X2_W + XM_W;               // shared multiplier product
  localparam int X3_W = P_W - FRAC_BITS;           // |x2*x| after the shift
  localparam int F_W  = X3_W + 1;                  // signed f(x)
  localparam int S_W  = F_W + 2;                   // headroom for 3*x3 - 2*x - 5

  // register widths
  localparam int CNT_W = 8;
  localparam int TOL_W = 23;
  localparam int RES_W = 39;

  localparam logic [CNT_W-1:0] MAX_ITER_RST = CNT_W'(100);
  localparam logic [TOL_W-1:0] TOL_RST      = TOL_W'(33);
  localparam logic [RES_W-1:0] RESID_RST    = RES_W'(3);

  // configuration port
  localparam int DATA_W    = 64;
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 2;
  localparam int REG_LSB   = 3;

  localparam logic [REG_IDX_W-1:0] REG_MAX_ITER = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_TOL      = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_RESID    = 2'd2;

  typedef enum logic [1:0] {
    ST_WIDTH = 2'd0,
    ST_RESID = 2'd1,
    ST_LIMIT = 2'd2,
    ST_NONE  = 2'd3
  } brfc_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ,
    S_CUBE,
    S_FIN,
    S_POST,
    S_DONE
  } brfc_state_e;

  typedef enum logic [1:0] {
    TGT_A,
    TGT_B,
    TGT_C
  } brfc_tgt_e;

  typedef struct packed {
    logic signed [X_W-1:0] lo_start;
    logic signed [X_W-1:0] hi_start;
  } brfc_req_t;

  typedef struct packed {
    logic signed [X_W-1:0] root;
    logic [CNT_W-1:0]      iterations;
    logic [1:0]            status;
  } brfc_res_t;

  typedef struct packed {
    logic         load;      // take a new interval, counter to one
    logic         mul_sq;    // product <= |x| * |x|
    logic         mul_cube;  // product <= |x2| * |x|
    logic         fin;       // f <= 3*x3 - 2*x - 5
    logic         save_fa;   // sign of f(a) <= sign of f
    logic         save_fb;   // sign of f(b) <= sign of f
    logic         next_b;    // operand <= b
    logic         update;    // move an endpoint to the midpoint
    logic         cnt_inc;
    logic         mid;       // midpoint and operand <= (a + b) >>> 1
    logic         emit;      // result goes to the output register
    brfc_status_e code;
  } brfc_cmd_t;

  typedef struct packed {
    logic multi;      // the limit lets the loop run at all
    logic width_ok;   // |b - a| < tolerance
    logic resid_ok;   // |f| < residual limit
    logic more_next;  // counter + 1 still below the limit
  } brfc_stat_t;

endpackage

### rtl/core/brfc_dp.sv
// datapath: interval ends, midpoint, shared multiplier, cubic evaluation,
// convergence tests and iteration counter; depends on brfc_pkg

module brfc_dp import brfc_pkg::*; (
  input  logic             clk_i,
  input  brfc_cmd_t        cmd_i,
  input  brfc_req_t        req_i,
  input  logic [CNT_W-1:0] max_iter_i,
  input  logic [TOL_W-1:0] tol_i,
  input  logic [RES_W-1:0] resid_i,
  output brfc_stat_t       stat_o,
  output logic [X_W-1:0]   root_o,
  output logic [CNT_W-1:0] cnt_o
);

  logic signed [X_W-1:0] a_q, b_q, c_q, x_q;
  logic [P_W-1:0]        p_q;
  logic [F_W-1:0]        f_q;
  logic                  fa_pos_q, fa_neg_q, fb_pos_q, fb_neg_q;
  logic [CNT_W-1:0]      cnt_q;

  logic [XM_W-1:0]  xm;
  logic [X2_W-1:0]  mul_a;
  logic [P_W-1:0]   prod;
  logic [X3_W-1:0]  x3m;
  logic [S_W-1:0]   x3e, x3s, xe, f_full;
  logic             f_neg, f_pos;
  logic [F_W-1:0]   f_mag;
  logic [X_W:0]     diff, d_mag;
  logic             b_upd, a_upd, fbp_nx, fbn_nx;
  logic [X_W-1:0]   a_src, b_src;
  logic [X_W:0]     sum;
  logic [X_W-1:0]   mid_nx;
  logic [CNT_W:0]   cnt_p1;

  localparam logic [S_W-1:0] FIVE = S_W'(5) << FRAC_BITS;

  // sign-magnitude operands; products truncate the magnitude
  assign xm    = x_q[X_W-1] ? (~x_q + XM_W'(1)) : x_q;
  assign mul_a = cmd_i.mul_sq ? X2_W'(xm) : p_q[FRAC_BITS +: X2_W];
  assign prod  = P_W'(mul_a) * P_W'(xm);

  assign x3m    = p_q[FRAC_BITS +: X3_W];
  assign x3e    = S_W'(x3m);
  assign x3s    = x_q[X_W-1] ? (~x3e + S_W'(1)) : x3e;
  assign xe     = {{(S_W-X_W){x_q[X_W-1]}}, x_q};
  assign f_full = x3s + (x3s << 1) - (xe << 1) - FIVE;

  assign f_neg = f_q[F_W-1];
  assign f_pos = !f_neg && (f_q != '0);
  assign f_mag = f_neg ? (~f_q + F_W'(1)) : f_q;

  assign diff  = {b_q[X_W-1], b_q} - {a_q[X_W-1], a_q};
  assign d_mag = diff[X_W] ? (~diff + (X_W+1)'(1)) : diff;

  // b moves first, then a is tested against the new f(b)
  assign b_upd  = (fa_pos_q && f_neg) || (fa_neg_q && f_pos);
  assign fbp_nx = b_upd ? f_pos : fb_pos_q;
  assign fbn_nx = b_upd ? f_neg : fb_neg_q;
  assign a_upd  = (f_pos && fbn_nx) || (f_neg && fbp_nx);

  always_comb begin
    a_src = a_q;
    b_src = b_q;
    if (cmd_i.load) begin
      a_src = req_i.lo_start;
      b_src = req_i.hi_start;
    end else if (cmd_i.update) begin
      if (a_upd) a_src = c_q;
      if (b_upd) b_src = c_q;
    end
  end

  assign sum    = {a_src[X_W-1], a_src} + {b_src[X_W-1], b_src};
  assign mid_nx = sum[X_W:1];

  assign cnt_p1 = {1'b0, cnt_q} + (CNT_W+1)'(1);

  assign stat_o.multi     = max_iter_i > CNT_W'(1);
  assign stat_o.width_ok  = d_mag < (X_W+1)'(tol_i);
  assign stat_o.resid_ok  = f_mag < F_W'(resid_i);
  assign stat_o.more_next = cnt_p1 < {1'b0, max_iter_i};

  assign root_o = c_q;
  assign cnt_o  = cnt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load || cmd_i.update) begin
      a_q <= a_src;
      b_q <= b_src;
    end
    if (cmd_i.load || cmd_i.mid) c_q <= mid_nx;

    if (cmd_i.load)        x_q <= req_i.lo_start;
    else if (cmd_i.mid)    x_q <= mid_nx;
    else if (cmd_i.next_b) x_q <= b_q;

    if (cmd_i.mul_sq || cmd_i.mul_cube) p_q <= prod;
    if (cmd_i.fin) f_q <= f_full[F_W-1:0];

    if (cmd_i.save_fa || (cmd_i.update && a_upd)) begin
      fa_pos_q <= f_pos;
      fa_neg_q <= f_neg;
    end
    if (cmd_i.save_fb || cmd_i.update) begin
      fb_pos_q <= cmd_i.save_fb ? f_pos : fbp_nx;
      fb_neg_q <= cmd_i.save_fb ? f_neg : fbn_nx;
    end

    if (cmd_i.load)         cnt_q <= CNT_W'(1);
    else if (cmd_i.cnt_inc) cnt_q <= cnt_p1[CNT_W-1:0];
  end

endmodule

### rtl/core/brfc_ctrl.sv
// controller state machine: sequences the cubic evaluations and the
// bisection loop, decides the result status; depends on brfc_pkg

module brfc_ctrl import brfc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       out_free_i,
  input  brfc_stat_t stat_i,
  output logic       in_ready_o,
  output brfc_cmd_t  cmd_o
);

  brfc_state_e  state_q, state_d;
  brfc_tgt_e    tgt_q, tgt_d;
  brfc_status_e code_q, code_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tgt_q   <= TGT_A;
      code_q  <= ST_NONE;
    end else begin
      state_q <= state_d;
      tgt_q   <= tgt_d;
      code_q  <= code_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    tgt_d      = tgt_q;
    code_d     = code_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.code = code_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (stat_i.multi) begin
            tgt_d   = TGT_A;
            state_d = S_SQ;
          end else begin
            code_d  = ST_NONE;
            state_d = S_DONE;
          end
        end
      end
      S_SQ: begin
        cmd_o.mul_sq = 1'b1;
        state_d      = S_CUBE;
      end
      S_CUBE: begin
        cmd_o.mul_cube = 1'b1;
        state_d        = S_FIN;
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = S_POST;
      end
      S_POST: begin
        unique case (tgt_q)
          TGT_A: begin
            cmd_o.save_fa = 1'b1;
            cmd_o.next_b  = 1'b1;
            tgt_d         = TGT_B;
            state_d       = S_SQ;
          end
          TGT_B: begin
            cmd_o.save_fb = 1'b1;
            cmd_o.mid     = 1'b1;
            tgt_d         = TGT_C;
            state_d       = S_SQ;
          end
          default: begin
            priority if (stat_i.width_ok) begin
              code_d  = ST_WIDTH;
              state_d = S_DONE;
            end else if (stat_i.resid_ok) begin
              code_d  = ST_RESID;
              state_d = S_DONE;
            end else begin
              cmd_o.update  = 1'b1;
              cmd_o.cnt_inc = 1'b1;
              if (stat_i.more_next) begin
                cmd_o.mid = 1'b1;
                state_d   = S_SQ;
              end else begin
                code_d  = ST_LIMIT;
                state_d = S_DONE;
              end
            end
          end
        endcase
      end
      S_DONE: begin
        if (out_free_i) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

### rtl/core/bisection_root_finder_cubic_unit.sv
// bisection root finder for 3x^3 - 2x - 5: top level with register port,
// output register, controller and datapath; depends on brfc_pkg, brfc_ctrl, brfc_dp
// every f(x) goes through the single shared multiplier in the steps square, cube,
//   sum, decide; f(lo) and f(hi) come first, then f of each midpoint; with an
//   iteration limit of 0 or 1 no f(x) is evaluated at all
// throughput: one request at a time; the next request is taken once the result
//   sits in the output register. reset: limits to 100 / 33 / 3, no result held

module bisection_root_finder_cubic_unit import brfc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  brfc_req_t         in_req_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output brfc_res_t         out_res_o,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [CNT_W-1:0] max_iter_q;
  logic [TOL_W-1:0] tol_q;
  logic [RES_W-1:0] resid_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic             cfg_we;

  brfc_cmd_t  cmd;
  brfc_stat_t stat;
  logic [X_W-1:0]   root;
  logic [CNT_W-1:0] cnt;

  logic      out_valid_q;
  brfc_res_t out_res_q;
  logic      out_free;

  // register file, one 64-bit slot per register
  assign pready  = 1'b1;
  assign reg_idx = paddr[REG_LSB +: REG_IDX_W];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= MAX_ITER_RST;
      tol_q      <= TOL_RST;
      resid_q    <= RESID_RST;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_MAX_ITER: max_iter_q <= pwdata[CNT_W-1:0];
        REG_TOL:      tol_q      <= pwdata[TOL_W-1:0];
        REG_RESID:    resid_q    <= pwdata[RES_W-1:0];
        default:      ;  // no register there, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MAX_ITER: prdata = DATA_W'(max_iter_q);
      REG_TOL:      prdata = DATA_W'(tol_q);
      REG_RESID:    prdata = DATA_W'(resid_q);
      default:      prdata = '0;
    endcase
  end

  // sequencing of evaluations and loop decisions
  brfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .stat_i     (stat),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  // interval, multiplier and tests
  brfc_dp u_dp (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .req_i      (in_req_i),
    .max_iter_i (max_iter_q),
    .tol_i      (tol_q),
    .resid_i    (resid_q),
    .stat_o     (stat),
    .root_o     (root),
    .cnt_o      (cnt)
  );

  // output register decouples a stalled consumer from the next request
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.emit) begin
      out_res_q.root       <= root;
      out_res_q.iterations <= cnt;
      out_res_q.status     <= cmd.code;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  // one request in flight: busy right after a request is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken while the previous one is still running");

  // a result never overwrites one that has not been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  // limit status carries the configured limit as its count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && (cmd.code == ST_LIMIT)) |=> (out_res_o.iterations == max_iter_q))
    else $error("limit status with wrong iteration count");

  // no loop pass means a count of one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && (cmd.code == ST_NONE)) |=> (out_res_o.iterations == CNT_W'(1)))
    else $error("no-iteration status with wrong count");

endmodule

### tb/sv/testbench.sv
// self-checking bench for the cubic bisection root finder: directed probes, then
// random intervals over several limit settings, each result checked against a typed value or a local model
// depends on brfc_pkg and bisection_root_finder_cubic_unit

module testbench import brfc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // limit register set as the block holds it
  typedef struct packed {
    logic [CNT_W-1:0] iters;
    logic [TOL_W-1:0] tol;
    logic [RES_W-1:0] resid;
  } limits_t;

  // one directed probe: which limit set, the interval, and a typed result where obvious
  typedef struct packed {
    logic [2:0]            cfg;
    logic signed [X_W-1:0] lo;
    logic signed [X_W-1:0] hi;
    logic                  known;
    logic signed [X_W-1:0] root;
    logic [CNT_W-1:0]      iters;
    brfc_status_e          st;
  } probe_t;

  // index past the end of the register list, writes there must be dropped
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam int X_MIN       = -(1 << (X_W - 1));
  localparam int X_MAX       = (1 << (X_W - 1)) - 1;
  localparam int ROOT_NEAR   = 89900;  // f changes sign near 1.3717
  localparam int QUIET_LIMIT = 5000;   // quiet cycles before the bench gives up; covers the slowest pass plus stalls
  localparam int N_PHASES    = 6;
  localparam int PHASE_ITEMS = 75;
  localparam int N_PROBES    = 19;

  localparam logic [127:0] PRODUCT_CAP = (128'd1 << 60) - 1;

  localparam limits_t LIMIT_SETS [7] = '{
    '{MAX_ITER_RST, TOL_RST, RESID_RST},        // after reset
    '{8'd1, 23'd33, 39'd3},                     // loop never runs
    '{8'd0, 23'd33, 39'd3},                     // loop never runs, zero limit
    '{8'd255, 23'd0, 39'd0},                    // only the counter can stop it
    '{8'd100, 23'h7fffff, 39'h7f_ffff_ffff},    // widest thresholds
    '{8'd2, 23'd0, 39'h7f_ffff_ffff},           // residual stops the first pass
    '{MAX_ITER_RST, TOL_RST, RESID_RST}         // back to the reset values
  };

  localparam probe_t PROBES [N_PROBES] = '{
    // reset limits
    '{3'd0, 24'sh010000, 24'sh020000, 1'b0, 24'sh0, 8'd0, ST_WIDTH},
    '{3'd0, 24'sh020000, 24'sh010000, 1'b0, 24'sh0, 8'd0, ST_WIDTH},  // reversed
    '{3'd0, 24'sh800000, 24'sh7fffff, 1'b0, 24'sh0, 8'd0, ST_WIDTH},  // full range
    '{3'd0, 24'sh010000, 24'sh010000, 1'b1, 24'sh010000, 8'd1, ST_WIDTH},
    '{3'd0, 24'sh030000, 24'sh040000, 1'b0, 24'sh0, 8'd0, ST_WIDTH},  // no sign change
    '{3'd0, 24'sh800000, 24'sh800000, 1'b1, 24'sh800000, 8'd1, ST_WIDTH},
    '{3'd0, 24'sh7fffff, 24'sh7fffff, 1'b1, 24'sh7fffff, 8'd1, ST_WIDTH},
    '{3'd0, 24'sh000000, 24'sh000000, 1'b1, 24'sh000000, 8'd1, ST_WIDTH},
    // no iteration: first midpoint comes back
    '{3'd1, 24'sh010000, 24'sh020000, 1'b1, 24'sh018000, 8'd1, ST_NONE},
    '{3'd1, 24'sh800000, 24'sh7fffff, 1'b1, 24'shffffff, 8'd1, ST_NONE},
    '{3'd2, 24'sh7fffff, 24'sh7fffff, 1'b1, 24'sh7fffff, 8'd1, ST_NONE},
    '{3'd2, 24'sh800000, 24'sh800001, 1'b1, 24'sh800000, 8'd1, ST_NONE},
    // counter limit at its top, thresholds at zero
    '{3'd3, 24'sh010000, 24'sh020000, 1'b0, 24'sh0, 8'd0, ST_WIDTH},
    '{3'd3, 24'sh800000, 24'sh7fffff, 1'b0, 24'sh0, 8'd0, ST_WIDTH},
    '{3'd3, 24'sh7fffff, 24'sh800000, 1'b0, 24'sh0, 8'd0, ST_WIDTH},
    // widest thresholds, then the residual set and the reset values again
    '{3'd4, 24'sh000000, 24'sh010000, 1'b1, 24'sh008000, 8'd1, ST_WIDTH},
    '{3'd4, 24'sh800000, 24'sh7fffff, 1'b1, 24'shffffff, 8'd1, ST_RESID},
    '{3'd5, 24'sh030000, 24'sh040000, 1'b1, 24'sh038000, 8'd1, ST_RESID},
    '{3'd6, 24'shfe0000, 24'sh030000, 1'b0, 24'sh0, 8'd0, ST_WIDTH}
  };

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  brfc_req_t         in_req_i    = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  brfc_res_t         out_res_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [ADDR_W-1:0] paddr       = '0;
  logic [DATA_W-1:0] pwdata      = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // local copy of the limit registers, follows every write
  limits_t   lim = '{MAX_ITER_RST, TOL_RST, RESID_RST};

  // results still owed by the block, oldest first
  brfc_res_t pending_roots [$];
  int        roots_owed   = 0;
  brfc_res_t head_root;
  int        fails        = 0;
  int        quiet_cycles = 0;
  int        stall_left   = 0;
  bit        no_idle      = 1'b0;

  // the request being offered, with a typed result when the probe has one
  logic      want_known = 1'b0;
  brfc_res_t want_res   = '0;

  bisection_root_finder_cubic_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_res_o  (out_res_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- model

  // x*y >> FRAC_BITS on magnitudes, so the product truncates toward zero
  function automatic longint scaled_product(longint x, longint y);
    logic [127:0] p;
    logic         neg;
    longint       ux;
    longint       uy;
    neg = (x < 0) != (y < 0);
    ux  = (x < 0) ? -x : x;
    uy  = (y < 0) ? -y : y;
    p   = 128'(ux) * 128'(uy);
    p   = p >> FRAC_BITS;
    if (p > PRODUCT_CAP) p = PRODUCT_CAP;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  // 3x^3 - 2x - 5 in Q24.16
  function automatic longint cubic_at(longint x);
    longint x2;
    longint x3;
    x2 = scaled_product(x, x);
    x3 = scaled_product(x2, x);
    return 3 * x3 - 2 * x - (longint'(5) << FRAC_BITS);
  endfunction

  function automatic int sign_of(longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  function automatic brfc_res_t bisect_cubic(brfc_req_t rq);
    longint       a;
    longint       b;
    longint       c;
    longint       fc;
    longint       span;
    int unsigned  n;
    brfc_status_e st;
    brfc_res_t    r;
    a  = rq.lo_start;
    b  = rq.hi_start;
    c  = (a + b) >>> 1;
    n  = 1;
    st = ST_NONE;
    if (n < lim.iters) begin
      st = ST_LIMIT;
      while (n < lim.iters) begin
        c    = (a + b) >>> 1;
        fc   = cubic_at(c);
        span = (b > a) ? b - a : a - b;
        // width test goes first
        if (span < longint'(lim.tol)) begin
          st = ST_WIDTH;
          break;
        end
        if (((fc < 0) ? -fc : fc) < longint'(lim.resid)) begin
          st = ST_RESID;
          break;
        end
        // a zero sign on either side leaves that end alone
        if (sign_of(cubic_at(a)) * sign_of(fc) < 0) b = c;
        if (sign_of(fc) * sign_of(cubic_at(b)) < 0) a = c;
        n++;
      end
    end
    r.root       = c[X_W-1:0];
    r.iterations = n[CNT_W-1:0];
    r.status     = st;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  // mostly back to back or short, now and then a long pause
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic int clip_x(int v);
    if (v < X_MIN) return X_MIN;
    if (v > X_MAX) return X_MAX;
    return v;
  endfunction

  function automatic brfc_req_t draw_interval();
    int        r;
    int        lo;
    int        hi;
    int        t;
    brfc_req_t q;
    r = $urandom_range(99);
    if (r < 70) begin
      // brackets the real root, ends at random log-spread distances
      lo = clip_x(ROOT_NEAR - 1 - int'($urandom >> $urandom_range(9, 31)));
      hi = clip_x(ROOT_NEAR + 1 + int'($urandom >> $urandom_range(9, 31)));
      if (r >= 55) begin
        t  = lo;
        lo = hi;
        hi = t;
      end
    end else if (r < 85) begin
      // anything at all, often without a sign change
      lo = int'($urandom);
      hi = int'($urandom);
    end else begin
      // narrow interval anywhere, either order
      lo = int'($urandom_range(0, 16777215)) - 8388608;
      hi = clip_x(lo + int'($urandom_range(0, 128)) - 64);
    end
    q.lo_start = X_W'(lo);
    q.hi_start = X_W'(hi);
    return q;
  endfunction

  // offer one request and hold it until taken; entered and left at a falling edge
  task automatic send_interval(brfc_req_t rq, logic known, brfc_res_t res);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= rq;
    want_known <= known;
    want_res   <= res;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // write one register, then read it back unless it lies past the list
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] held;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx) << REG_LSB;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_MAX_ITER: lim.iters = data[CNT_W-1:0];
      REG_TOL:      lim.tol   = data[TOL_W-1:0];
      REG_RESID:    lim.resid = data[RES_W-1:0];
      default:      ;
    endcase
    @(negedge clk_i);
    if (idx != REG_SPARE) begin
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      case (idx)
        REG_MAX_ITER: held = DATA_W'(lim.iters);
        REG_TOL:      held = DATA_W'(lim.tol);
        default:      held = DATA_W'(lim.resid);
      endcase
      if (prdata !== held) begin
        $error("prdata: expected %0h, got %0h", held, prdata);
        fails++;
      end
      @(negedge clk_i);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // new limits only once every owed result is out; upper data bits carry junk
  task automatic program_limits(limits_t s);
    logic [DATA_W-1:0] d;
    in_valid_i <= 1'b0;
    while (roots_owed != 0) @(negedge clk_i);
    d = {$urandom, $urandom};
    d[CNT_W-1:0] = s.iters;
    write_reg(REG_MAX_ITER, d);
    d = {$urandom, $urandom};
    d[TOL_W-1:0] = s.tol;
    write_reg(REG_TOL, d);
    d = {$urandom, $urandom};
    d[RES_W-1:0] = s.resid;
    write_reg(REG_RESID, d);
    write_reg(REG_SPARE, {$urandom, $urandom});
  endtask

  // ---------------------------------------------------------------- result side

  // ready drops for random stretches; no new stretch starts while no_idle holds
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else begin
      out_ready_i <= 1'b1;
      if (!no_idle) stall_left <= pick_gap();
    end
  end

  // record accepted requests, check results in order, watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        pending_roots.push_back(want_known ? want_res : bisect_cubic(in_req_i));
        roots_owed++;
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_roots.size() == 0) begin
          $error("result with no request outstanding: root %0d", out_res_o.root);
          fails++;
        end else begin
          head_root = pending_roots.pop_front();
          roots_owed--;
          if (out_res_o.root !== head_root.root) begin
            $error("root: expected %0d, got %0d", head_root.root, out_res_o.root);
            fails++;
          end
          if (out_res_o.iterations !== head_root.iterations) begin
            $error("iterations: expected %0d, got %0d",
                   head_root.iterations, out_res_o.iterations);
            fails++;
          end
          if (out_res_o.status !== head_root.status) begin
            $error("status: expected %0d, got %0d", head_root.status, out_res_o.status);
            fails++;
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- main sequence

  initial begin
    int        set_now;
    brfc_req_t rq;
    brfc_res_t rs;
    limits_t   pick;
    int        r;
    set_now = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed probes, limits changed between groups
    for (int k = 0; k < N_PROBES; k++) begin
      if (PROBES[k].cfg != set_now) begin
        program_limits(LIMIT_SETS[PROBES[k].cfg]);
        set_now = PROBES[k].cfg;
      end
      rq.lo_start   = PROBES[k].lo;
      rq.hi_start   = PROBES[k].hi;
      rs.root       = PROBES[k].root;
      rs.iterations = PROBES[k].iters;
      rs.status     = PROBES[k].st;
      send_interval(rq, PROBES[k].known, rs);
    end

    // random phases, each with its own limits
    for (int p = 0; p < N_PHASES; p++) begin
      r = $urandom_range(9);
      if (r == 0) pick.iters = CNT_W'($urandom_range(0, 3));
      else if (r == 1) pick.iters = 8'd255;
      else pick.iters = CNT_W'($urandom_range(4, 120));
      r = $urandom_range(9);
      if (r == 0) pick.tol = '0;
      else if (r == 1) pick.tol = TOL_W'($urandom);
      else pick.tol = TOL_W'($urandom_range(1, 2000));
      r = $urandom_range(9);
      if (r == 0) pick.resid = '0;
      else if (r == 1) pick.resid = RES_W'({$urandom, $urandom});
      else pick.resid = RES_W'($urandom_range(0, 5000));
      program_limits(pick);
      no_idle = ($urandom_range(3) == 0);
      repeat (PHASE_ITEMS) send_interval(draw_interval(), 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    while (roots_owed != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
    if (fails == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
